### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Both forms sample on the rising edge of clock and are off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RAR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rational arith assertion failed");

// Next-cycle implication.
`define RAR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rational arith assertion failed");

`endif

### rtl/core/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Shared constants, codes and controller/datapath interface types for the
// rational arithmetic unit.
// ----------------------------------------------------------------------------
package rar_pkg;

   // Default operand width and fixed result widths.
   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int RES_NUM_WIDTH     = 33;
   localparam int RES_DEN_WIDTH     = 32;
   localparam int CMD_WIDTH         = 2;
   localparam int EXT_WIDTH         = 64;

   // Operation codes.
   localparam logic [CMD_WIDTH-1:0] CMD_ADD = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_MUL = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_INC = 2'd2;

   // Multiplier operand selection.
   localparam logic [1:0] MSEL_AX = 2'd0;  // a_num times b_den or b_num
   localparam logic [1:0] MSEL_BA = 2'd1;  // b_num times a_den
   localparam logic [1:0] MSEL_DD = 2'd2;  // a_den times b_den

   // Divider operand selection.
   localparam logic [1:0] DSEL_REM = 2'd0;  // gcd remainder m rem n
   localparam logic [1:0] DSEL_NUM = 2'd1;  // numerator over gcd
   localparam logic [1:0] DSEL_DEN = 2'd2;  // denominator over gcd

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       sum_en;
      logic       err_set;
      logic       div_start;
      logic [1:0] div_sel;
      logic       gcd_step;
      logic       qn_en;
      logic       qd_en;
      logic       out_load;
   } rar_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic err;
      logic n_zero;
      logic m_zero;
      logic div_done;
   } rar_status_type;

endpackage

### rtl/core/rar_div.sv
// ----------------------------------------------------------------------------
// rar_div
// Signed truncating divider, one quotient bit per cycle (restoring).
// Gives quotient and remainder with C semantics.
// ----------------------------------------------------------------------------
module rar_div #(
   parameter int VW = 2 * rar_pkg::OPERAND_WIDTH_DEF + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [VW-1:0] dividend,
   input  logic signed [VW-1:0] divisor,
   output logic                 done,
   output logic signed [VW-1:0] quot,
   output logic signed [VW-1:0] rem
);
   localparam int CW = $clog2(VW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] q_ff, q_in;
   logic [VW-1:0] r_ff, r_in;
   logic [VW-1:0] d_ff, d_in;
   logic          sq_ff, sq_in;
   logic          sr_ff, sr_in;

   logic [VW-1:0] x_mag;
   logic [VW-1:0] y_mag;
   logic [VW:0]   r_sh;
   logic [VW:0]   r_diff;
   logic          fits;
   logic          last;

   // Operand magnitudes; the most negative value maps to its unsigned magnitude.
   assign x_mag = dividend[VW-1] ? (~$unsigned(dividend) + 1'b1) : $unsigned(dividend);
   assign y_mag = divisor[VW-1]  ? (~$unsigned(divisor) + 1'b1)  : $unsigned(divisor);

   // One restoring step.
   assign r_sh   = {r_ff, q_ff[VW-1]};
   assign r_diff = r_sh - {1'b0, d_ff};
   assign fits   = (r_sh >= {1'b0, d_ff});
   assign last   = (cnt_ff == CW'(VW - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      sq_in   = sq_ff;
      sr_in   = sr_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = x_mag;
         r_in    = '0;
         d_in    = y_mag;
         sq_in   = dividend[VW-1] ^ divisor[VW-1];
         sr_in   = dividend[VW-1];
      end else if (busy_ff) begin
         q_in   = {q_ff[VW-2:0], fits};
         r_in   = fits ? r_diff[VW-1:0] : r_sh[VW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      q_ff  <= q_in;
      r_ff  <= r_in;
      d_ff  <= d_in;
      sq_ff <= sq_in;
      sr_ff <= sr_in;
   end

   // Quotient sign follows both operands, remainder sign follows the dividend.
   assign done = done_ff;
   assign quot = sq_ff ? $signed(~q_ff + 1'b1) : $signed(q_ff);
   assign rem  = sr_ff ? $signed(~r_ff + 1'b1) : $signed(r_ff);

endmodule

### rtl/core/rar_dpath.sv
// ----------------------------------------------------------------------------
// rar_dpath
// Datapath: operand registers, shared multiplier, raw fraction, gcd pair,
// shared divider and result register.
// ----------------------------------------------------------------------------
module rar_dpath #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [rar_pkg::CMD_WIDTH-1:0]         req_command,
   input  logic signed [OPERAND_WIDTH-1:0]       req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]       req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]       req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]       req_b_den,
   input  rar_pkg::rar_cmd_type                  cmd,
   output rar_pkg::rar_status_type               status,
   output logic signed [rar_pkg::RES_NUM_WIDTH-1:0] res_num,
   output logic signed [rar_pkg::RES_DEN_WIDTH-1:0] res_den,
   output logic                                  res_error
);
   import rar_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;
   localparam int VW = 2 * W + 1;

   logic [CMD_WIDTH-1:0] op_ff;
   logic signed [W-1:0]  an_ff, ad_ff, bn_ff, bd_ff;
   logic                 err_ff, err_in;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [VW-1:0] num_ff, num_in;
   logic signed [VW-1:0] den_ff, den_in;
   logic signed [VW-1:0] m_ff, n_ff;
   logic signed [VW-1:0] qn_ff, qd_ff;
   logic signed [RES_NUM_WIDTH-1:0] res_num_ff;
   logic signed [RES_DEN_WIDTH-1:0] res_den_ff;
   logic                 res_err_ff;

   logic                 err_load;
   logic signed [W-1:0]  mul_a, mul_b;
   logic signed [PW-1:0] prod;
   logic signed [VW-1:0] div_x, div_y;
   logic signed [VW-1:0] div_quot, div_rem;
   logic                 div_done;
   logic signed [EXT_WIDTH-1:0] qn_ext, qd_ext;

   // Operand checks on the incoming transaction.
   always_comb begin
      case (req_command)
         CMD_ADD: err_load = (req_a_den == '0) || (req_b_den == '0);
         CMD_MUL: err_load = (req_a_den == '0) || (req_b_den == '0);
         CMD_INC: err_load = (req_a_den == '0);
         default: err_load = 1'b1;
      endcase
   end

   always_comb begin
      err_in = err_ff;
      if (cmd.load) begin
         err_in = err_load;
      end else if (cmd.err_set) begin
         err_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= 1'b0;
      end else begin
         err_ff <= err_in;
      end
   end

   // Operand capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_command;
         an_ff <= req_a_num;
         ad_ff <= req_a_den;
         bn_ff <= req_b_num;
         bd_ff <= req_b_den;
      end
   end

   // Shared multiplier, one product per cycle.
   always_comb begin
      case (cmd.mul_sel)
         MSEL_AX: begin
            mul_a = an_ff;
            mul_b = (op_ff == CMD_MUL) ? bn_ff : bd_ff;
         end
         MSEL_BA: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         default: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MSEL_AX: p0_ff <= prod;
            MSEL_BA: p1_ff <= prod;
            default: p2_ff <= prod;
         endcase
      end
   end

   // Raw numerator and denominator.
   always_comb begin
      case (op_ff)
         CMD_ADD: begin
            num_in = VW'(p0_ff) + VW'(p1_ff);
            den_in = VW'(p2_ff);
         end
         CMD_MUL: begin
            num_in = VW'(p0_ff);
            den_in = VW'(p2_ff);
         end
         default: begin
            num_in = VW'(an_ff) + VW'(ad_ff);
            den_in = VW'(ad_ff);
         end
      endcase
   end

   // Raw fraction and the gcd working pair.
   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         num_ff <= num_in;
         den_ff <= den_in;
         m_ff   <= num_in;
         n_ff   <= den_in;
      end else if (cmd.gcd_step) begin
         m_ff <= n_ff;
         n_ff <= div_rem;
      end
   end

   // Divider operands: remainder step, or exact division by the gcd in m.
   always_comb begin
      case (cmd.div_sel)
         DSEL_REM: begin
            div_x = m_ff;
            div_y = n_ff;
         end
         DSEL_NUM: begin
            div_x = num_ff;
            div_y = m_ff;
         end
         default: begin
            div_x = den_ff;
            div_y = m_ff;
         end
      endcase
   end

   rar_div #(
      .VW(VW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_x),
      .divisor  (div_y),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // Reduced fraction.
   always_ff @(posedge clock) begin
      if (cmd.qn_en) begin
         qn_ff <= div_quot;
      end
      if (cmd.qd_en) begin
         qd_ff <= div_quot;
      end
   end

   // Result register; an error gives zero over zero.
   assign qn_ext = EXT_WIDTH'(qn_ff);
   assign qd_ext = EXT_WIDTH'(qd_ff);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         res_num_ff <= err_ff ? '0 : qn_ext[RES_NUM_WIDTH-1:0];
         res_den_ff <= err_ff ? '0 : qd_ext[RES_DEN_WIDTH-1:0];
         res_err_ff <= err_ff;
      end
   end

   assign status.err      = err_ff;
   assign status.n_zero   = (n_ff == '0);
   assign status.m_zero   = (m_ff == '0);
   assign status.div_done = div_done;

   assign res_num   = res_num_ff;
   assign res_den   = res_den_ff;
   assign res_error = res_err_ff;

endmodule

### rtl/core/rar_ctrl.sv
// ----------------------------------------------------------------------------
// rar_ctrl
// Controller: sequences multiply, gcd loop and the two exact divisions, and
// runs both handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rar_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rar_pkg::rar_status_type status,
   output rar_pkg::rar_cmd_type    cmd
);
   import rar_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MUL0   = 4'd1;
   localparam logic [3:0] S_MUL1   = 4'd2;
   localparam logic [3:0] S_MUL2   = 4'd3;
   localparam logic [3:0] S_SUM    = 4'd4;
   localparam logic [3:0] S_GTEST  = 4'd5;
   localparam logic [3:0] S_GREM   = 4'd6;
   localparam logic [3:0] S_QN     = 4'd7;
   localparam logic [3:0] S_QD     = 4'd8;
   localparam logic [3:0] S_FINISH = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The result register can take a new value when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            if (status.err) begin
               state_in = S_FINISH;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MSEL_AX;
               state_in    = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_BA;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_DD;
            state_in    = S_SUM;
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = S_GTEST;
         end
         // Euclid loop test: a zero second value ends it with the gcd in m.
         S_GTEST: begin
            if (!status.n_zero) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_REM;
               state_in      = S_GREM;
            end else if (status.m_zero) begin
               cmd.err_set = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_NUM;
               state_in      = S_QN;
            end
         end
         S_GREM: begin
            if (status.div_done) begin
               cmd.gcd_step = 1'b1;
               state_in     = S_GTEST;
            end
         end
         S_QN: begin
            cmd.div_sel = DSEL_DEN;
            if (status.div_done) begin
               cmd.qn_en     = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_QD;
            end
         end
         S_QD: begin
            if (status.div_done) begin
               cmd.qd_en = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A waiting result is never overwritten.
   `RAR_ASSERT_IMP(a_no_overwrite, rsp_valid_ff && !rsp_ready, !cmd.out_load)
   // Only one transaction is in flight at a time.
   `RAR_ASSERT_NEXT(a_one_in_flight, cmd.load, !req_ready)
   // A divider start is never answered in the following cycle.
   `RAR_ASSERT_NEXT(a_div_latency, cmd.div_start, !status.div_done)

endmodule

### rtl/core/rational_arith_reduce.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Rational add, multiply and increment with gcd reduction of the result.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    command, a_num, a_den, b_num, b_den
// rsp      out        rsp_valid/rsp_ready    res_num, res_den, error
//
// One transaction is processed at a time; the next is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// The time from acceptance to a valid result grows with the number of Euclid
// remainder steps, as the bit-serial divider works through each division. An
// operand error skips the arithmetic and goes straight to the final state.
// Reset is synchronous and clears the controller, the divider control state and the error flag.
// A stalled result holds the controller in its final state until taken.
// ----------------------------------------------------------------------------
module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [rar_pkg::CMD_WIDTH-1:0]            req_command,
   input  logic signed [OPERAND_WIDTH-1:0]          req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]          req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]          req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]          req_b_den,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [rar_pkg::RES_NUM_WIDTH-1:0] rsp_res_num,
   output logic signed [rar_pkg::RES_DEN_WIDTH-1:0] rsp_res_den,
   output logic                                     rsp_error
);
   import rar_pkg::*;

   rar_cmd_type    cmd;
   rar_status_type status;

   // Sequencer.
   rar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic.
   rar_dpath #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_command (req_command),
      .req_a_num   (req_a_num),
      .req_a_den   (req_a_den),
      .req_b_num   (req_b_num),
      .req_b_den   (req_b_den),
      .cmd         (cmd),
      .status      (status),
      .res_num     (rsp_res_num),
      .res_den     (rsp_res_den),
      .res_error   (rsp_error)
   );

endmodule
